// ----- sv/interpolating_pulse_shaper_defines.svh -----
// Assertion macros for the interpolating pulse shaper checker.
// Expects clk, rst_n, sample_valid and sample_ready in the scope of use.
`ifndef INTERPOLATING_PULSE_SHAPER_DEFINES_SVH
`define INTERPOLATING_PULSE_SHAPER_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define IPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked in the cycle after an output stall
`define IPS_ASSERT_STALL(label, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (sample_valid && !sample_ready) |=> (cons)) else $error(msg);

`endif

// ----- sv/ips_pkg.sv -----
// Shared constants, codes and types of the interpolating pulse shaper.
// No dependencies.
package ips_pkg;

    localparam int DEF_MAX_SPS      = 16;
    localparam int DEF_MAX_TAPS     = 128;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam int TAP_INDEX_W = 7;
    localparam int COEF_W      = 16;
    localparam int SYM_W       = 16;
    localparam int SPS_CFG_W   = 5;
    localparam int NTAPS_CFG_W = 8;
    localparam int GAIN_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SPS_CFG_W-1:0]   SPS_RESET   = 5'd4;
    localparam logic [NTAPS_CFG_W-1:0] NTAPS_RESET = 8'd25;
    localparam logic [GAIN_W-1:0]      GAIN_RESET  = 16'h8000;

    // Q1.15 x Q1.15 products, split point of the gain multiply, rounding shift
    localparam int PROD_W    = COEF_W + SYM_W;
    localparam int ACC_LO_W  = 24;
    localparam int RND_SHIFT = 30;

    typedef enum logic {
        CMD_TAP_LOAD = 1'b0,
        CMD_SYMBOL   = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPS      = 2'd0,
        REG_NUM_TAPS = 2'd1,
        REG_GAIN     = 2'd2
    } reg_idx_t;

    // travels with each filter term down the MAC pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic last_sym;
        logic zero;
    } term_tag_t;

endpackage

// ----- sv/ips_item_if.sv -----
// Input channel: tap loads and symbols.
// Depends on ips_pkg.
interface ips_item_if import ips_pkg::*; ();

    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [TAP_INDEX_W-1:0]        tap_index;
    logic signed [COEF_W-1:0]      tap_value;
    logic signed [SYM_W-1:0]       sym_i;
    logic signed [SYM_W-1:0]       sym_q;

    modport source (output valid, cmd, tap_index, tap_value, sym_i, sym_q, input ready);
    modport sink   (input valid, cmd, tap_index, tap_value, sym_i, sym_q, output ready);

endinterface

// ----- sv/ips_sample_if.sv -----
// Output channel: shaped complex samples.
// Depends on ips_pkg.
interface ips_sample_if import ips_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) ();

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_i;
    logic signed [SAMPLE_WIDTH-1:0] out_q;
    logic                           last_of_symbol;

    modport source (output valid, out_i, out_q, last_of_symbol, input ready);
    modport sink   (input valid, out_i, out_q, last_of_symbol, output ready);

endinterface

// ----- sv/ips_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on ips_pkg.
interface ips_cfg_if import ips_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);

endinterface

// ----- sv/ips_ram.sv -----
// Single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies; used for the tap store and the symbol history.
module ips_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ips_ctrl.sv -----
// Sequencer: accepts items, writes the stores, walks the polyphase terms.
// Depends on ips_pkg.
module ips_ctrl import ips_pkg::*; #(
    parameter int MAX_SPS  = DEF_MAX_SPS,
    parameter int MAX_TAPS = DEF_MAX_TAPS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic                        item_cmd,
    input  logic [TAP_INDEX_W-1:0]      item_tap_index,
    input  logic [SPS_CFG_W-1:0]        sps_cfg,
    input  logic [NTAPS_CFG_W-1:0]      ntaps_cfg,
    output logic                        tap_we,
    output logic [$clog2(MAX_TAPS)-1:0] tap_waddr,
    output logic                        hist_we,
    output logic [$clog2(MAX_TAPS)-1:0] hist_waddr,
    output logic                        rd_en,
    output logic [$clog2(MAX_TAPS)-1:0] tap_raddr,
    output logic [$clog2(MAX_TAPS)-1:0] hist_raddr,
    output term_tag_t                   tag
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int P_W   = (MAX_SPS > 1) ? $clog2(MAX_SPS) : 1;
    localparam int SPS_W = $clog2(MAX_SPS + 1);
    localparam int NT_W  = $clog2(MAX_TAPS + 1);
    localparam int T_W   = $clog2(MAX_TAPS + MAX_SPS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [NT_W-1:0]  fill_reg, fill_next;
    logic [SPS_W-1:0] sps_reg, sps_next;
    logic [NT_W-1:0]  nt_reg, nt_next;
    logic [P_W-1:0]   phase_reg, phase_next;
    logic [T_W-1:0]   t_reg, t_next;
    logic [AW-1:0]    m_reg, m_next;
    logic [AW-1:0]    haddr_reg, haddr_next;

    logic             accept;
    logic             sym_accept;
    logic [AW-1:0]    ptr_inc;
    logic [SPS_W-1:0] sps_clamped;
    logic [NT_W-1:0]  nt_clamped;
    logic             run;
    logic             last_term;
    logic             last_phase;
    logic             dummy;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign sym_accept = accept && (cmd_t'(item_cmd) == CMD_SYMBOL);
    assign ptr_inc    = (ptr_reg == AW'(MAX_TAPS - 1)) ? '0 : ptr_reg + 1'b1;

    // loads past the end of the store are dropped
    assign tap_we     = accept && (cmd_t'(item_cmd) == CMD_TAP_LOAD)
                        && (int'(item_tap_index) < MAX_TAPS);
    assign tap_waddr  = AW'(item_tap_index);
    assign hist_we    = sym_accept;
    assign hist_waddr = ptr_inc;

    always_comb
    begin
        if (sps_cfg == '0)
        begin
            sps_clamped = SPS_W'(1);
        end
        else if (int'(sps_cfg) > MAX_SPS)
        begin
            sps_clamped = SPS_W'(MAX_SPS);
        end
        else
        begin
            sps_clamped = SPS_W'(sps_cfg);
        end

        if (ntaps_cfg == '0)
        begin
            nt_clamped = NT_W'(1);
        end
        else if (int'(ntaps_cfg) > MAX_TAPS)
        begin
            nt_clamped = NT_W'(MAX_TAPS);
        end
        else
        begin
            nt_clamped = NT_W'(ntaps_cfg);
        end
    end

    assign run        = (state_reg == ST_RUN);
    assign last_term  = ((T_W+1)'(t_reg) + (T_W+1)'(sps_reg)) >= (T_W+1)'(nt_reg);
    assign last_phase = (SPS_W'(phase_reg) + SPS_W'(1)) == sps_reg;
    // a phase with no taps still yields one (zero) sample
    assign dummy      = (T_W+1)'(t_reg) >= (T_W+1)'(nt_reg);

    assign rd_en        = run && adv;
    assign tap_raddr    = AW'(t_reg);
    assign hist_raddr   = haddr_reg;
    assign tag.valid    = run;
    assign tag.first    = (m_reg == '0);
    assign tag.last     = last_term;
    assign tag.last_sym = last_term && last_phase;
    // history entries not yet written since reset read as zero
    assign tag.zero     = dummy || (NT_W'(m_reg) >= fill_reg);

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        fill_next  = fill_reg;
        sps_next   = sps_reg;
        nt_next    = nt_reg;
        phase_next = phase_reg;
        t_next     = t_reg;
        m_next     = m_reg;
        haddr_next = haddr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (sym_accept)
                begin
                    state_next = ST_RUN;
                    ptr_next   = ptr_inc;
                    fill_next  = (fill_reg == NT_W'(MAX_TAPS)) ? fill_reg : fill_reg + 1'b1;
                    sps_next   = sps_clamped;
                    nt_next    = nt_clamped;
                    phase_next = '0;
                    t_next     = '0;
                    m_next     = '0;
                    haddr_next = ptr_inc;
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    if (last_term)
                    begin
                        phase_next = phase_reg + 1'b1;
                        t_next     = T_W'(phase_reg) + T_W'(1);
                        m_next     = '0;
                        haddr_next = ptr_reg;
                        if (last_phase)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        t_next     = t_reg + T_W'(sps_reg);
                        m_next     = m_reg + 1'b1;
                        haddr_next = (haddr_reg == '0) ? AW'(MAX_TAPS - 1)
                                                       : haddr_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            fill_reg  <= '0;
            sps_reg   <= SPS_W'(1);
            nt_reg    <= NT_W'(1);
            phase_reg <= '0;
            t_reg     <= '0;
            m_reg     <= '0;
            haddr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            fill_reg  <= fill_next;
            sps_reg   <= sps_next;
            nt_reg    <= nt_next;
            phase_reg <= phase_next;
            t_reg     <= t_next;
            m_reg     <= m_next;
            haddr_reg <= haddr_next;
        end
    end

endmodule

// ----- sv/ips_mac.sv -----
// Complex MAC pipeline: tap x history products, accumulation, gain,
// round half up and saturation. Depends on ips_pkg.
module ips_mac import ips_pkg::*; #(
    parameter int MAX_TAPS     = DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  term_tag_t                      tag_issue,
    input  logic [COEF_W-1:0]              tap_rdata,
    input  logic [2*SYM_W-1:0]             hist_rdata,
    input  logic [GAIN_W-1:0]              gain,
    output logic                           res_valid,
    output logic                           res_last_sym,
    output logic signed [SAMPLE_WIDTH-1:0] res_i,
    output logic signed [SAMPLE_WIDTH-1:0] res_q
);

    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
    localparam int HI_W  = ACC_W - ACC_LO_W;
    localparam int HP_W  = HI_W + GAIN_W + 1;
    localparam int LP_W  = ACC_LO_W + GAIN_W;
    localparam int SUM_W = ACC_W + GAIN_W + 2;

    localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(1) <<< (RND_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX  =
        (SUM_W'(1) <<< (SAMPLE_WIDTH - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_MIN  = -SAT_MAX - SUM_W'(1);

    term_tag_t                 tag_d_reg;
    term_tag_t                 tag_m_reg;
    logic signed [PROD_W-1:0]  prod_i_reg, prod_q_reg;
    logic signed [ACC_W-1:0]   acc_i_reg, acc_q_reg;
    logic signed [ACC_W-1:0]   acc_base_i, acc_base_q;
    logic signed [ACC_W-1:0]   acc_sum_i, acc_sum_q;
    logic signed [ACC_W-1:0]   s0_i_reg, s0_q_reg;
    logic                      s0_valid_reg, s0_last_reg;
    logic signed [HP_W-1:0]    hi_prod_i_reg, hi_prod_q_reg;
    logic [LP_W-1:0]           lo_prod_i_reg, lo_prod_q_reg;
    logic                      s1_valid_reg, s1_last_reg;

    // acc * gain = hi * gain * 2^ACC_LO_W + lo * gain, then floor((x + 2^29) / 2^30)
    function automatic logic [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [HP_W-1:0] hi_p,
        input logic [LP_W-1:0]        lo_p
    );
        logic signed [SUM_W-1:0] total;
        logic signed [SUM_W-1:0] shifted;
        logic [SAMPLE_WIDTH-1:0] r;
        total   = (SUM_W'(hi_p) <<< ACC_LO_W) + $signed(SUM_W'(lo_p)) + RND_BIAS;
        shifted = total >>> RND_SHIFT;
        if (shifted > SAT_MAX)
        begin
            r = SAT_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            r = SAT_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            r = shifted[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_d_reg    <= '0;
            tag_m_reg    <= '0;
            s0_valid_reg <= 1'b0;
            s0_last_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            tag_d_reg    <= tag_issue;
            tag_m_reg    <= tag_d_reg;
            s0_valid_reg <= tag_m_reg.valid && tag_m_reg.last;
            s0_last_reg  <= tag_m_reg.last_sym;
            s1_valid_reg <= s0_valid_reg;
            s1_last_reg  <= s0_last_reg;
        end
    end

    always_comb
    begin
        acc_base_i = tag_m_reg.first ? '0 : acc_i_reg;
        acc_base_q = tag_m_reg.first ? '0 : acc_q_reg;
        acc_sum_i  = acc_base_i + ACC_W'(prod_i_reg);
        acc_sum_q  = acc_base_q + ACC_W'(prod_q_reg);
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (tag_d_reg.zero)
            begin
                prod_i_reg <= '0;
                prod_q_reg <= '0;
            end
            else
            begin
                prod_i_reg <= $signed(tap_rdata) * $signed(hist_rdata[SYM_W-1:0]);
                prod_q_reg <= $signed(tap_rdata) * $signed(hist_rdata[2*SYM_W-1:SYM_W]);
            end

            if (tag_m_reg.valid)
            begin
                acc_i_reg <= acc_sum_i;
                acc_q_reg <= acc_sum_q;
                if (tag_m_reg.last)
                begin
                    s0_i_reg <= acc_sum_i;
                    s0_q_reg <= acc_sum_q;
                end
            end

            hi_prod_i_reg <= $signed(s0_i_reg[ACC_W-1:ACC_LO_W]) * $signed({1'b0, gain});
            hi_prod_q_reg <= $signed(s0_q_reg[ACC_W-1:ACC_LO_W]) * $signed({1'b0, gain});
            lo_prod_i_reg <= s0_i_reg[ACC_LO_W-1:0] * gain;
            lo_prod_q_reg <= s0_q_reg[ACC_LO_W-1:0] * gain;
        end
    end

    assign res_valid    = s1_valid_reg;
    assign res_last_sym = s1_last_reg;
    assign res_i        = $signed(round_sat(hi_prod_i_reg, lo_prod_i_reg));
    assign res_q        = $signed(round_sat(hi_prod_q_reg, lo_prod_q_reg));

endmodule

// ----- sv/interpolating_pulse_shaper.sv -----
// Interpolating pulse shaper, top level: config registers, stores, output beat.
// Depends on ips_pkg, the channel interfaces, ips_ram, ips_ctrl and ips_mac.
//
// Use:
//   items   - one beat per tap load (cmd 0) or symbol (cmd 1).
//   samples - one beat per output phase, sps of them per symbol; last_of_symbol
//             marks the final one. Tap loads give no beats.
//   cfg     - register writes (0 sps, 1 num_taps, 2 gain),
//             always ready; issue them only while the block is drained.
// A tap load leaves items.ready high. A symbol holds items.ready low while
// its terms are read: one term per tap in use plus one for each phase beyond
// num_taps. The tap store and history RAMs each give one read per cycle
// unless the samples channel stalls. The last sample of a phase leaves through
// the RAM read, product, accumulator, gain product and output registers.
// Reset zeroes the history pointer and the fill count (unwritten history
// reads as zero) and loads the register reset values; taps must be loaded.
// A stalled samples channel freezes the whole MAC pipeline; item accepts
// continue until the sequencer itself is busy.
module interpolating_pulse_shaper import ips_pkg::*; #(
    parameter int MAX_SPS      = DEF_MAX_SPS,
    parameter int MAX_TAPS     = DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    ips_item_if.sink            items,
    ips_sample_if.source        samples,
    ips_cfg_if.sink             cfg
);

    localparam int AW = $clog2(MAX_TAPS);

    logic [SPS_CFG_W-1:0]   sps_cfg_reg;
    logic [NTAPS_CFG_W-1:0] ntaps_cfg_reg;
    logic [GAIN_W-1:0]      gain_cfg_reg;

    logic                   adv;
    logic                   tap_we, hist_we, rd_en;
    logic [AW-1:0]          tap_waddr, hist_waddr, tap_raddr, hist_raddr;
    logic [COEF_W-1:0]      tap_rdata;
    logic [2*SYM_W-1:0]     hist_rdata;
    term_tag_t              tag_issue;

    logic                           res_valid, res_last_sym;
    logic signed [SAMPLE_WIDTH-1:0] res_i, res_q;

    logic                           out_valid_reg;
    logic                           out_last_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_i_reg, out_q_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sps_cfg_reg   <= SPS_RESET;
            ntaps_cfg_reg <= NTAPS_RESET;
            gain_cfg_reg  <= GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_SPS:      sps_cfg_reg   <= cfg.data[SPS_CFG_W-1:0];
                REG_NUM_TAPS: ntaps_cfg_reg <= cfg.data[NTAPS_CFG_W-1:0];
                REG_GAIN:     gain_cfg_reg  <= cfg.data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // pipeline moves unless a finished beat is held by the receiver
    assign adv = !out_valid_reg || samples.ready;

    ips_ctrl #(
        .MAX_SPS  (MAX_SPS),
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .item_valid     (items.valid),
        .item_ready     (items.ready),
        .item_cmd       (items.cmd),
        .item_tap_index (items.tap_index),
        .sps_cfg        (sps_cfg_reg),
        .ntaps_cfg      (ntaps_cfg_reg),
        .tap_we         (tap_we),
        .tap_waddr      (tap_waddr),
        .hist_we        (hist_we),
        .hist_waddr     (hist_waddr),
        .rd_en          (rd_en),
        .tap_raddr      (tap_raddr),
        .hist_raddr     (hist_raddr),
        .tag            (tag_issue)
    );

    ips_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (items.tap_value),
        .re    (rd_en),
        .raddr (tap_raddr),
        .rdata (tap_rdata)
    );

    ips_ram #(
        .WIDTH (2 * SYM_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata ({items.sym_q, items.sym_i}),
        .re    (rd_en),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    ips_mac #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .tag_issue    (tag_issue),
        .tap_rdata    (tap_rdata),
        .hist_rdata   (hist_rdata),
        .gain         (gain_cfg_reg),
        .res_valid    (res_valid),
        .res_last_sym (res_last_sym),
        .res_i        (res_i),
        .res_q        (res_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && res_valid)
        begin
            out_i_reg    <= res_i;
            out_q_reg    <= res_q;
            out_last_reg <= res_last_sym;
        end
    end

    assign samples.valid          = out_valid_reg;
    assign samples.out_i          = out_i_reg;
    assign samples.out_q          = out_q_reg;
    assign samples.last_of_symbol = out_last_reg;

endmodule

// ----- sv/ips_checker.sv -----
// Port-level checks on the interpolating pulse shaper, bound to the top level.
// Depends on ips_pkg and interpolating_pulse_shaper_defines.svh.
`include "interpolating_pulse_shaper_defines.svh"

module ips_checker import ips_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    item_valid,
    input logic                    item_ready,
    input logic                    item_cmd,
    input logic                    sample_valid,
    input logic                    sample_ready,
    input logic [SAMPLE_WIDTH-1:0] sample_i,
    input logic [SAMPLE_WIDTH-1:0] sample_q,
    input logic                    sample_last
);

    logic sym_beat;
    logic tap_beat;

    assign sym_beat = item_valid && item_ready && (item_cmd == CMD_SYMBOL);
    assign tap_beat = item_valid && item_ready && (item_cmd == CMD_TAP_LOAD);

    `IPS_ASSERT_STALL(a_out_valid_held, sample_valid, "output beat dropped while stalled")
    `IPS_ASSERT_STALL(a_out_data_held, $stable(sample_i) && $stable(sample_q) && $stable(sample_last), "output beat changed while stalled")
    `IPS_ASSERT_NEXT(a_sym_busy, sym_beat, !item_ready, "symbol accepted but sequencer not busy")
    `IPS_ASSERT_NEXT(a_tap_single, tap_beat, item_ready, "tap load held the input channel")

endmodule

bind interpolating_pulse_shaper ips_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ips_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (items.valid),
    .item_ready   (items.ready),
    .item_cmd     (items.cmd),
    .sample_valid (samples.valid),
    .sample_ready (samples.ready),
    .sample_i     (samples.out_i),
    .sample_q     (samples.out_q),
    .sample_last  (samples.last_of_symbol)
);
